[src/hdmsc_pkg.sv]
package hdmsc_pkg;

   // Stream payload widths.
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 16;

   // Field layout of the request beat.
   localparam int COORD_XZ_BITS = 28;
   localparam int COORD_Y_BITS  = 8;
   localparam int SAMPLE_W      = 16;
   localparam int X_LSB         = 0;
   localparam int Y_LSB         = X_LSB + COORD_XZ_BITS;
   localparam int Z_LSB         = Y_LSB + COORD_Y_BITS;
   localparam int FILL_LSB      = Z_LSB + COORD_XZ_BITS;

   // Key layout: x at bit 0, z at bit 28, y at bit 56.
   localparam int KEY_W     = 64;
   localparam int KEY_Z_POS = 28;
   localparam int KEY_Y_POS = 56;

   // Finalizer constants of the 64-bit mixer.
   localparam logic [63:0] FMIX_C1    = 64'hFF51AFD7ED558CCD;
   localparam logic [63:0] FMIX_C2    = 64'hC4CEB9FE1A85EC53;
   localparam int          FMIX_SHIFT = 33;

   // Defaults for the top-level parameters.
   localparam int DEF_ENTRIES     = 1024;
   localparam int DEF_SAMPLE_BITS = 16;

   // Request kinds carried in req_tuser.
   localparam logic ACTION_LOOKUP = 1'b0;
   localparam logic ACTION_FILL   = 1'b1;

   function automatic logic [KEY_W-1:0] fmix_xorshift(input logic [KEY_W-1:0] k);
      return k ^ (k >> FMIX_SHIFT);
   endfunction

endpackage

[src/hashed_direct_mapped_sample_cache.sv]
// Direct-mapped sample cache keyed by a 3D integer coordinate.
//
// Request channel (req_*): one beat per operation. req_tuser selects a lookup
// or a fill; req_tdata carries the coordinate and, for a fill, the sample.
// Response channel (rsp_*): exactly one beat per request, in request order.
// rsp_tuser is the hit flag, rsp_tdata the sample (stored sample on a hit,
// written sample on a fill, zero on a miss).
//
// Each request is hashed with the 64-bit murmur3 finalizer. The two 64-bit
// multiplies run on one shared set of 32-bit partial-product multipliers,
// each multiply as a partial-product step and a sum step, followed by the
// synchronous memory read and the tag compare. One request is in flight
// at a time: a new request is taken only once the response to the last
// one is registered, so a fill is always visible to the next lookup.
//
// After reset the block sweeps both memories to zero, one entry per cycle,
// with req_tready low. A stalled response waits in the output register;
// the next request is still accepted and holds in the compare step until
// the output register frees up.
module hashed_direct_mapped_sample_cache #(
   parameter int ENTRIES     = hdmsc_pkg::DEF_ENTRIES,
   parameter int SAMPLE_BITS = hdmsc_pkg::DEF_SAMPLE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // coord_x[27:0], coord_y[35:28], coord_z[63:36], fill_sample[79:64]
   input  logic [hdmsc_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // sample_out[15:0]
   output logic [hdmsc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // hit[0]
   output logic                             rsp_tuser
);
   import hdmsc_pkg::*;

   localparam int                IDX_W    = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0]  IDX_MASK = IDX_W'(ENTRIES - 1);
   localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL1,
      ST_SUM1,
      ST_MUL2,
      ST_SUM2,
      ST_READ,
      ST_RESP
   } state_type;

   state_type              state_ff;
   logic [IDX_W-1:0]       clr_addr_ff;
   logic                   action_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [KEY_W-1:0]       k_ff;
   logic [SAMPLE_BITS-1:0] fill_ff;
   logic [63:0]            p_ll_ff;
   logic [31:0]            p_lh_ff;
   logic [31:0]            p_hl_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [KEY_W-1:0]       tag_rd_ff;
   logic [SAMPLE_BITS-1:0] smp_rd_ff;
   logic                   rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic                   rsp_tuser_ff;

   logic [KEY_W-1:0]       tag_mem [ENTRIES];
   logic [SAMPLE_BITS-1:0] smp_mem [ENTRIES];

   logic [KEY_W-1:0]       key_in;
   logic [63:0]            mul_c;
   logic [63:0]            prod_in;
   logic [KEY_W-1:0]       k_in;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [KEY_W-1:0]       mem_wtag;
   logic [SAMPLE_BITS-1:0] mem_wsmp;
   logic                   accept;
   logic                   out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign key_in = {req_tdata[Z_LSB-1:Y_LSB],
                    req_tdata[FILL_LSB-1:Z_LSB],
                    req_tdata[Y_LSB-1:X_LSB]};

   assign mul_c = (state_ff == ST_MUL2) ? FMIX_C2 : FMIX_C1;

   // Low 64 bits of the product: the high-by-high term falls off the top.
   assign prod_in = p_ll_ff + {p_lh_ff + p_hl_ff, 32'b0};
   assign k_in    = fmix_xorshift(prod_in);

   // The clearing sweep and fills share the single write port.
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wtag  = '0;
         mem_wsmp  = '0;
      end else begin
         mem_we    = (state_ff == ST_READ) && (action_ff == ACTION_FILL);
         mem_waddr = idx_ff;
         mem_wtag  = key_ff;
         mem_wsmp  = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_waddr] <= mem_wtag;
      end
      tag_rd_ff <= tag_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         smp_mem[mem_waddr] <= mem_wsmp;
      end
      smp_rd_ff <= smp_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // In the compare step a taken beat is replaced by the next one below.
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_RESP)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == IDX_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  action_ff <= req_tuser;
                  key_ff    <= key_in;
                  k_ff      <= fmix_xorshift(key_in);
                  fill_ff   <= SAMPLE_BITS'(req_tdata[REQ_TDATA_W-1:FILL_LSB]);
                  state_ff  <= ST_MUL1;
               end
            end
            ST_MUL1, ST_MUL2: begin
               p_ll_ff  <= 64'(k_ff[31:0]) * 64'(mul_c[31:0]);
               p_lh_ff  <= k_ff[31:0] * mul_c[63:32];
               p_hl_ff  <= k_ff[63:32] * mul_c[31:0];
               state_ff <= (state_ff == ST_MUL1) ? ST_SUM1 : ST_SUM2;
            end
            ST_SUM1: begin
               k_ff     <= k_in;
               state_ff <= ST_MUL2;
            end
            ST_SUM2: begin
               idx_ff   <= k_in[IDX_W-1:0] & IDX_MASK;
               state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  if (action_ff == ACTION_FILL) begin
                     rsp_tuser_ff <= 1'b0;
                     rsp_tdata_ff <= RSP_TDATA_W'(fill_ff);
                  end else if (tag_rd_ff == key_ff) begin
                     rsp_tuser_ff <= 1'b1;
                     rsp_tdata_ff <= RSP_TDATA_W'(smp_rd_ff);
                  end else begin
                     rsp_tuser_ff <= 1'b0;
                     rsp_tdata_ff <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

[src/hdmsc_checker.sv]
module hdmsc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [hdmsc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [hdmsc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser
);
   import hdmsc_pkg::*;

   logic req_beat;

   assign req_beat = req_tvalid && req_tready;

   // No response may be pending coming out of reset.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Only one request is in flight, so a beat closes the request channel.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_tready)
      else $error("request accepted while another is in flight");

   // The hash takes several cycles, so no response can start right after a beat.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !$rose(rsp_tvalid))
      else $error("response appeared one cycle after a request beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

endmodule

bind hashed_direct_mapped_sample_cache hdmsc_checker u_hdmsc_checker (.*);

[tb/tb_hashed_direct_mapped_sample_cache.sv]
module tb_hashed_direct_mapped_sample_cache;
   timeunit 1ns;
   timeprecision 1ps;

   import hdmsc_pkg::*;

   localparam int          ENTRIES     = DEF_ENTRIES;
   localparam int          STALL_LIMIT = 4000;
   localparam int          HOLD_CYCLES = 300;
   localparam int          POOL_MAX    = 48;
   localparam logic [27:0] XZ_MAX      = 28'h7FFFFFF;
   localparam logic [27:0] XZ_MIN      = 28'h8000000;
   localparam logic [27:0] XZ_ONES     = 28'hFFFFFFF;
   localparam logic [7:0]  Y_MAX       = 8'h7F;
   localparam logic [7:0]  Y_MIN       = 8'h80;

   typedef struct packed {
      logic        action;
      logic [27:0] x;
      logic [7:0]  y;
      logic [27:0] z;
      logic [15:0] smp;
   } cache_req_t;

   typedef struct packed {
      logic        hit;
      logic [15:0] smp;
   } cache_rsp_t;

   typedef struct packed {
      logic        action;
      logic [27:0] x;
      logic [7:0]  y;
      logic [27:0] z;
      logic [15:0] smp;
      logic        typed;
      logic        want_hit;
      logic [15:0] want_smp;
   } dir_row_t;

   localparam int DIR_ROWS = 22;

   // Rows with typed set carry an expectation that follows directly from the
   // cleared stores or from the fill rule; the rest go through the predictor.
   dir_row_t dir_tab [DIR_ROWS] = '{
      '{ACTION_LOOKUP, 28'h0,   8'h0,  28'h0,   16'h0000, 1'b1, 1'b1, 16'h0000},
      '{ACTION_LOOKUP, XZ_MAX,  Y_MAX, XZ_MAX,  16'h0000, 1'b1, 1'b0, 16'h0000},
      '{ACTION_LOOKUP, XZ_MIN,  Y_MIN, XZ_MIN,  16'hFFFF, 1'b1, 1'b0, 16'h0000},
      '{ACTION_FILL,   XZ_MAX,  Y_MAX, XZ_MAX,  16'hFFFF, 1'b1, 1'b0, 16'hFFFF},
      '{ACTION_LOOKUP, XZ_MAX,  Y_MAX, XZ_MAX,  16'h0000, 1'b1, 1'b1, 16'hFFFF},
      '{ACTION_FILL,   XZ_MIN,  Y_MIN, XZ_MIN,  16'h0000, 1'b1, 1'b0, 16'h0000},
      '{ACTION_LOOKUP, XZ_MIN,  Y_MIN, XZ_MIN,  16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ACTION_LOOKUP, XZ_MAX,  Y_MIN, XZ_MAX,  16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ACTION_FILL,   28'h0,   8'h0,  28'h0,   16'h1234, 1'b1, 1'b0, 16'h1234},
      '{ACTION_LOOKUP, 28'h0,   8'h0,  28'h0,   16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ACTION_FILL,   28'h0,   8'h0,  28'h0,   16'hABCD, 1'b1, 1'b0, 16'hABCD},
      '{ACTION_LOOKUP, 28'h0,   8'h0,  28'h0,   16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ACTION_FILL,   XZ_ONES, 8'hFF, XZ_ONES, 16'h8000, 1'b1, 1'b0, 16'h8000},
      '{ACTION_LOOKUP, XZ_ONES, 8'hFF, XZ_ONES, 16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ACTION_LOOKUP, 28'h1,   8'h0,  28'h0,   16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ACTION_LOOKUP, 28'h0,   8'h1,  28'h0,   16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ACTION_LOOKUP, 28'h0,   8'h0,  28'h1,   16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ACTION_FILL,   28'h1,   8'h0,  28'h0,   16'h0001, 1'b1, 1'b0, 16'h0001},
      '{ACTION_LOOKUP, 28'h1,   8'h0,  28'h0,   16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ACTION_FILL,   XZ_MAX,  8'h0,  XZ_MIN,  16'h5A5A, 1'b1, 1'b0, 16'h5A5A},
      '{ACTION_LOOKUP, XZ_MIN,  8'h0,  XZ_MAX,  16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ACTION_LOOKUP, XZ_MAX,  8'h0,  XZ_MIN,  16'hFFFF, 1'b0, 1'b0, 16'h0000}
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // coord_x[27:0], coord_y[35:28], coord_z[63:36], fill_sample[79:64]
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // action[0]
   logic                   req_tuser  = ACTION_LOOKUP;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // sample_out[15:0]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // hit[0]
   logic                   rsp_tuser;

   hashed_direct_mapped_sample_cache u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   logic [63:0] shadow_tag    [ENTRIES];
   logic [15:0] shadow_sample [ENTRIES];
   cache_rsp_t  expected_rsp  [$];
   cache_req_t  coord_pool    [$];
   int unsigned err_count = 0;
   bit          calm      = 1'b0;
   bit          hold_req  = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      err_count++;
   endtask

   function automatic logic [63:0] mix64(input logic [63:0] k);
      logic [63:0] m;
      m = k ^ (k >> FMIX_SHIFT);
      m = m * FMIX_C1;
      m = m ^ (m >> FMIX_SHIFT);
      m = m * FMIX_C2;
      m = m ^ (m >> FMIX_SHIFT);
      return m;
   endfunction

   // Applies one request to the shadow stores and returns its response.
   function automatic cache_rsp_t cache_lookup_fill(input cache_req_t r);
      cache_rsp_t  o;
      logic [63:0] key;
      int          slot;
      key  = {r.y, r.z, r.x};
      slot = int'(mix64(key) & 64'(ENTRIES - 1));
      o    = '0;
      if (r.action == ACTION_FILL) begin
         shadow_tag[slot]    = key;
         shadow_sample[slot] = r.smp;
         o.smp               = r.smp;
      end else if (shadow_tag[slot] == key) begin
         o.hit = 1'b1;
         o.smp = shadow_sample[slot];
      end
      return o;
   endfunction

   task automatic drive_req(input cache_req_t r, input logic typed, input cache_rsp_t want);
      cache_rsp_t pred;
      req_tvalid <= 1'b1;
      req_tuser  <= r.action;
      req_tdata  <= {r.smp, r.z, r.y, r.x};
      do @(posedge clock); while (!req_tready);
      pred = cache_lookup_fill(r);
      expected_rsp.push_back(typed ? want : pred);
      if (!calm && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   function automatic cache_req_t random_coord();
      cache_req_t c;
      c = '0;
      if ($urandom_range(99) < 15) begin
         // Coordinates around the origin crowd a few keys together.
         c.x = 28'($urandom_range(0, 6) - 3);
         c.y = 8'($urandom_range(0, 6) - 3);
         c.z = 28'($urandom_range(0, 6) - 3);
      end else begin
         c.x = 28'($urandom);
         c.y = 8'($urandom);
         c.z = 28'($urandom);
      end
      case ($urandom_range(9))
         0:       c.smp = 16'h0000;
         1:       c.smp = 16'hFFFF;
         default: c.smp = 16'($urandom);
      endcase
      return c;
   endfunction

   // Half the requests reuse coordinates filled earlier, as lookups or as
   // overwriting fills, so hits and overwrites are common; the rest are fresh fills and lookups that should miss.
   function automatic cache_req_t next_random_req();
      cache_req_t  r;
      cache_req_t  p;
      int unsigned pick;
      pick     = $urandom_range(99);
      r        = random_coord();
      r.action = ACTION_LOOKUP;
      if (coord_pool.size() != 0) begin
         p = coord_pool[$urandom_range(coord_pool.size() - 1)];
      end else begin
         p = r;
      end
      if (pick < 40) begin
         r.x = p.x;
         r.y = p.y;
         r.z = p.z;
      end else if (pick < 65) begin
         r.action = ACTION_FILL;
         if (coord_pool.size() >= POOL_MAX) begin
            void'(coord_pool.pop_front());
         end
         coord_pool.push_back(r);
      end else if (pick < 75) begin
         r.action = ACTION_FILL;
         r.x      = p.x;
         r.y      = p.y;
         r.z      = p.z;
      end else if (pick >= 90) begin
         r.action = $urandom_range(1) ? ACTION_FILL : ACTION_LOOKUP;
      end
      return r;
   endfunction

   task automatic send_random(input int unsigned count);
      repeat (count) drive_req(next_random_req(), 1'b0, '0);
   endtask

   task automatic drain_expected();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   // Response side ready, with random backpressure and one long hold-off.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 25);
         end
      end
   end

   always @(posedge clock) begin
      cache_rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected beat sample", rsp_tdata, '0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_tuser !== want.hit) begin
               report_mismatch("hit", 16'(rsp_tuser), 16'(want.hit));
            end
            if (rsp_tdata !== want.smp) begin
               report_mismatch("sample", rsp_tdata, want.smp);
            end
         end
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      cache_req_t r;
      cache_rsp_t w;
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_tag[i]    = '0;
         shadow_sample[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         r = {dir_tab[i].action, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].smp};
         w = {dir_tab[i].want_hit, dir_tab[i].want_smp};
         drive_req(r, dir_tab[i].typed, w);
      end

      send_random(500);

      // Sender waits for every outstanding response before the calm stretch.
      drain_expected();
      calm = 1'b1;
      send_random(300);
      calm = 1'b0;

      // The receiver stalls long enough for the block to back up to its input.
      hold_req = 1'b1;
      send_random(150);

      send_random(380);

      drain_expected();
      repeat (12) @(posedge clock);
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[sim.f]
src/hdmsc_pkg.sv
src/hashed_direct_mapped_sample_cache.sv
src/hdmsc_checker.sv
tb/tb_hashed_direct_mapped_sample_cache.sv
